// ----- rtl/sks_pkg.sv -----
// Shared constants, state encoding and control bundle for the scalar Kalman smoother.
package sks_pkg;

    // Default field widths
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int GAIN_FRAC_DEF    = 24;

    // Covariance and noise registers, unsigned Q32.16
    localparam int COV_W = 48;
    localparam logic [COV_W-1:0] COV_ONE = COV_W'(65536);

    // Shared adder width: holds a doubled divider remainder below 2^(COV_W+2)
    localparam int ADD_W = COV_W + 2;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // Register index, taken from paddr[3]
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    // Sequencer steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_Q,
        S_ADD_R,
        S_DIV,
        S_DIFF,
        S_NEG,
        S_MUL_K,
        S_RND,
        S_UPD_X,
        S_INV_K,
        S_MUL_P,
        S_FIN
    } t_state;

    // Control from sequencer to datapath
    typedef struct packed {
        t_state state;
        logic   load;
        logic   commit;
    } t_ctrl;

endpackage

// ----- rtl/sks_ctrl.sv -----
// Sequencer that steps the shared adder through one filter update.
module sks_ctrl #(
    parameter int GAIN_FRACTION_BITS = sks_pkg::GAIN_FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_free,
    output logic          o_ready,
    output sks_pkg::t_ctrl o_ctrl
);

    localparam int CNT_W = $clog2(GAIN_FRACTION_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_FRACTION_BITS);

    sks_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             cnt_done;

    // State and iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sks_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign cnt_done = (r_cnt == CNT_LAST);

    // Next step and strobes
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        o_ready = 1'b0;
        o_ctrl.state  = r_state;
        o_ctrl.load   = 1'b0;
        o_ctrl.commit = 1'b0;
        unique case (r_state)
            sks_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = sks_pkg::S_ADD_Q;
                end
            end
            sks_pkg::S_ADD_Q: n_state = sks_pkg::S_ADD_R;
            sks_pkg::S_ADD_R: n_state = sks_pkg::S_DIV;
            sks_pkg::S_DIV: begin
                if (cnt_done) begin
                    n_state = sks_pkg::S_DIFF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sks_pkg::S_DIFF:  n_state = sks_pkg::S_NEG;
            sks_pkg::S_NEG:   n_state = sks_pkg::S_MUL_K;
            sks_pkg::S_MUL_K: begin
                if (cnt_done) begin
                    n_state = sks_pkg::S_RND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sks_pkg::S_RND:   n_state = sks_pkg::S_UPD_X;
            sks_pkg::S_UPD_X: n_state = sks_pkg::S_INV_K;
            sks_pkg::S_INV_K: n_state = sks_pkg::S_MUL_P;
            sks_pkg::S_MUL_P: begin
                if (cnt_done) begin
                    n_state = sks_pkg::S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sks_pkg::S_FIN: begin
                // hold until the output register is free
                if (i_out_free) begin
                    o_ctrl.commit = 1'b1;
                    n_state       = sks_pkg::S_IDLE;
                end
            end
            default: n_state = sks_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- rtl/sks_datapath.sv -----
// Filter state, operand registers and the single shared add/subtract unit.
module sks_datapath #(
    parameter int SAMPLE_WIDTH       = sks_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = sks_pkg::GAIN_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sks_pkg::t_ctrl              i_ctrl,
    input  logic [SAMPLE_WIDTH-1:0]     i_measurement,
    input  logic                        i_start_of_series,
    input  logic [sks_pkg::COV_W-1:0]   i_process_noise,
    input  logic [sks_pkg::COV_W-1:0]   i_measurement_noise,
    output logic [SAMPLE_WIDTH-1:0]     o_estimate,
    output logic [GAIN_FRACTION_BITS:0] o_gain
);

    localparam int AW = sks_pkg::ADD_W;
    localparam int CW = sks_pkg::COV_W;
    localparam int SW = SAMPLE_WIDTH;
    localparam int G  = GAIN_FRACTION_BITS;
    localparam logic [AW-1:0] GAIN_ONE = {{(AW-1){1'b0}}, 1'b1} << G;

    // Filter state
    logic [SW-1:0] r_x;
    logic [CW-1:0] r_p;
    logic          r_started;

    // Working registers
    logic [SW-1:0] r_z;
    logic [CW-1:0] r_p1;
    logic [AW-1:0] r_opnd;
    logic [AW-1:0] r_acc;
    logic [G:0]    r_k;
    logic [G:0]    r_mlo;
    logic          r_neg;
    logic          r_dz;

    // Shared adder
    logic [AW-1:0] add_a, add_b, add_b_eff;
    logic          add_inv, add_cin;
    logic [AW:0]   add_sum;
    logic [AW-1:0] z_ext, x_ext;
    logic [CW-1:0] p1_sat;
    logic          ge;

    assign z_ext = {{(AW-SW){r_z[SW-1]}}, r_z};
    assign x_ext = {{(AW-SW){r_x[SW-1]}}, r_x};

    // Select operands for the current step
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_inv = 1'b0;
        add_cin = 1'b0;
        unique case (i_ctrl.state)
            sks_pkg::S_ADD_Q: begin
                add_a = {2'b00, r_p};
                add_b = {2'b00, i_process_noise};
            end
            sks_pkg::S_ADD_R: begin
                add_a = {2'b00, r_p1};
                add_b = {2'b00, i_measurement_noise};
            end
            sks_pkg::S_DIV: begin
                add_a   = r_acc;
                add_b   = r_opnd;
                add_inv = 1'b1;
                add_cin = 1'b1;
            end
            sks_pkg::S_DIFF: begin
                add_a   = z_ext;
                add_b   = x_ext;
                add_inv = 1'b1;
                add_cin = 1'b1;
            end
            sks_pkg::S_NEG: begin
                add_b   = r_opnd;
                add_inv = r_neg;
                add_cin = r_neg;
            end
            sks_pkg::S_MUL_K, sks_pkg::S_MUL_P: begin
                add_a = r_acc;
                add_b = r_mlo[0] ? r_opnd : '0;
            end
            sks_pkg::S_RND: begin
                add_a   = {r_acc[AW-2:0], r_mlo[G]};
                add_cin = r_mlo[G-1];
            end
            sks_pkg::S_UPD_X: begin
                add_a   = x_ext;
                add_b   = r_opnd;
                add_inv = r_neg;
                add_cin = r_neg;
            end
            sks_pkg::S_INV_K: begin
                add_a   = GAIN_ONE;
                add_b   = {{(AW-G-1){1'b0}}, r_k};
                add_inv = 1'b1;
                add_cin = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_b_eff = add_inv ? ~add_b : add_b;
    assign add_sum   = {1'b0, add_a} + {1'b0, add_b_eff} + {{AW{1'b0}}, add_cin};
    assign ge        = add_sum[AW];
    assign p1_sat    = add_sum[CW] ? {CW{1'b1}} : add_sum[CW-1:0];

    // Estimate, covariance and series flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_p       <= sks_pkg::COV_ONE;
            r_started <= 1'b0;
        end else begin
            if (i_ctrl.load && (i_start_of_series || !r_started)) begin
                r_x       <= i_measurement;
                r_p       <= sks_pkg::COV_ONE;
                r_started <= 1'b1;
            end
            if (i_ctrl.state == sks_pkg::S_UPD_X) begin
                r_x <= add_sum[SW-1:0];
            end
            if (i_ctrl.commit) begin
                r_p <= {r_acc[CW-2:0], r_mlo[G]};
            end
        end
    end

    // Working registers advance one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_z <= i_measurement;
        end
        case (i_ctrl.state)
            sks_pkg::S_ADD_Q: begin
                r_p1 <= p1_sat;
            end
            sks_pkg::S_ADD_R: begin
                r_opnd <= add_sum[AW-1:0];
                r_acc  <= {2'b00, r_p1};
                r_dz   <= (add_sum[CW:0] == '0);
                r_k    <= (add_sum[CW:0] == '0) ? GAIN_ONE[G:0] : '0;
            end
            sks_pkg::S_DIV: begin
                // restoring division, one quotient bit a cycle
                if (!r_dz) begin
                    r_acc <= {(ge ? add_sum[AW-2:0] : r_acc[AW-2:0]), 1'b0};
                    r_k   <= {r_k[G-1:0], ge};
                end
            end
            sks_pkg::S_DIFF: begin
                r_opnd <= add_sum[AW-1:0];
                r_neg  <= add_sum[AW-1];
            end
            sks_pkg::S_NEG: begin
                r_opnd <= add_sum[AW-1:0];
                r_acc  <= '0;
                r_mlo  <= r_k;
            end
            sks_pkg::S_MUL_K, sks_pkg::S_MUL_P: begin
                // shift-and-add, one multiplier bit a cycle
                r_acc <= add_sum[AW:1];
                r_mlo <= {add_sum[0], r_mlo[G:1]};
            end
            sks_pkg::S_RND: begin
                r_opnd <= add_sum[AW-1:0];
            end
            sks_pkg::S_INV_K: begin
                r_mlo  <= add_sum[G:0];
                r_acc  <= '0;
                r_opnd <= {2'b00, r_p1};
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    assign o_estimate = r_x;
    assign o_gain     = r_k;

endmodule

// ----- rtl/scalar_kalman_smoother.sv -----
// Top level of the scalar Kalman smoother: register port, channels and output register.
//
// Input channel (i_valid/o_ready) carries one signed Q23.8 sample and a start
// flag; a start, or the first sample after reset, reloads the estimate with
// the sample and the covariance with 1.0 before the update runs.
// Output channel (o_valid/i_ready) returns the new estimate and the gain used
// (unsigned, 2^GAIN_FRACTION_BITS is 1.0).
// Registers: process noise Q at byte address 0, measurement noise R at 8,
// both unsigned Q32.16, 48 bits in a 64-bit word, reset to 1.0.
// Each update runs to its last step and commits to the output register; o_valid
// rises in the same cycle that a new transaction can first be taken, so a new
// sample is taken only once the last one has been committed.
// The update is paced by the single shared adder: one bit a cycle through the
// gain division and through each of the two shift-and-add multiplies.
// While the block works on a sample o_ready is low. The result sits in an
// output register; if the receiver stalls, the next sample is still taken and
// its update runs, then holds in its last step until the register is free.
// Reset is synchronous: estimate 0, covariance 1.0, no series started.
module scalar_kalman_smoother #(
    parameter int SAMPLE_WIDTH       = sks_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = sks_pkg::GAIN_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_measurement,
    input  logic                              i_start_of_series,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    o_estimate,
    output logic [GAIN_FRACTION_BITS:0]       o_gain,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sks_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sks_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sks_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CW = sks_pkg::COV_W;

    logic [CW-1:0]               r_process_noise;
    logic [CW-1:0]               r_measurement_noise;
    logic                        r_out_valid;
    logic [SAMPLE_WIDTH-1:0]     r_estimate;
    logic [GAIN_FRACTION_BITS:0] r_gain;

    sks_pkg::t_ctrl              ctrl;
    logic                        out_free;
    logic                        cfg_write;
    logic [SAMPLE_WIDTH-1:0]     dp_estimate;
    logic [GAIN_FRACTION_BITS:0] dp_gain;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise     <= sks_pkg::COV_ONE;
            r_measurement_noise <= sks_pkg::COV_ONE;
        end else if (cfg_write) begin
            unique case (paddr[3])
                sks_pkg::REG_PROCESS_NOISE:     r_process_noise     <= pwdata[CW-1:0];
                sks_pkg::REG_MEASUREMENT_NOISE: r_measurement_noise <= pwdata[CW-1:0];
                default:                        r_process_noise     <= r_process_noise;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            sks_pkg::REG_PROCESS_NOISE:
                prdata = {{(sks_pkg::CFG_DATA_W-CW){1'b0}}, r_process_noise};
            sks_pkg::REG_MEASUREMENT_NOISE:
                prdata = {{(sks_pkg::CFG_DATA_W-CW){1'b0}}, r_measurement_noise};
            default:
                prdata = '0;
        endcase
    end

    // Sequencer and datapath
    assign out_free = !r_out_valid || i_ready;

    sks_ctrl #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .o_ready    (o_ready),
        .o_ctrl     (ctrl)
    );

    sks_datapath #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .i_measurement       (i_measurement),
        .i_start_of_series   (i_start_of_series),
        .i_process_noise     (r_process_noise),
        .i_measurement_noise (r_measurement_noise),
        .o_estimate          (dp_estimate),
        .o_gain              (dp_gain)
    );

    // Output register: load on commit, drop once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit) begin
            r_estimate <= dp_estimate;
            r_gain     <= dp_gain;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_estimate = r_estimate;
    assign o_gain     = r_gain;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the scalar Kalman smoother: corner samples, then random series.
module testbench;
    import sks_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int GF            = GAIN_FRAC_DEF;
    localparam int WIDE_W        = COV_W + GF + 1;
    localparam int LATENCY       = 3 * GF + 11;
    localparam int HOLD_CYCLES   = 700;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 66;

    localparam logic [COV_W-1:0] COV_MAX  = '1;
    localparam logic [GF:0]      GAIN_ONE = {1'b1, {GF{1'b0}}};
    localparam logic [SW-1:0]    Z_MAX    = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0]    Z_MIN    = {1'b1, {(SW-1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [SW-1:0]         i_measurement;
    logic                  i_start_of_series;
    logic                  o_valid;
    logic                  i_ready;
    logic [SW-1:0]         o_estimate;
    logic [GF:0]           o_gain;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic sink_hold_req = 1'b0;

    // Holds its own copy of the filter state and the outputs still owed by the block
    class kalman_scoreboard;
        typedef struct {
            logic [SW-1:0] estimate;
            logic [GF:0]   gain;
        } filter_out_t;

        filter_out_t      due_outputs[$];
        logic [SW-1:0]    est;
        logic [COV_W-1:0] cov;
        logic [COV_W-1:0] q_noise;
        logic [COV_W-1:0] r_noise;
        logic             started;
        int errors, checked, samples, series;
        int saturations, zero_dens, unity_gains, zero_gains;

        function new();
            est         = '0;
            cov         = COV_ONE;
            q_noise     = COV_ONE;
            r_noise     = COV_ONE;
            started     = 1'b0;
            errors      = 0;
            checked     = 0;
            samples     = 0;
            series      = 0;
            saturations = 0;
            zero_dens   = 0;
            unity_gains = 0;
            zero_gains  = 0;
        endfunction

        function void set_noise(logic idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_PROCESS_NOISE) begin
                q_noise = value[COV_W-1:0];
            end else begin
                r_noise = value[COV_W-1:0];
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Run one filter update on an accepted sample and queue the output it owes
        function void take_sample(logic [SW-1:0] z, logic start);
            logic [COV_W:0]     p_sum;
            logic [COV_W-1:0]   p1;
            logic [COV_W:0]     den;
            logic [WIDE_W-1:0]  wide;
            logic [GF:0]        k;
            logic signed [SW:0] diff;
            logic [SW:0]        mag;
            logic [63:0]        adj;
            logic [SW:0]        x_new;
            filter_out_t        want;
            samples++;
            // Open a series: load the sample, covariance back to 1.0
            if (start || !started) begin
                est     = z;
                cov     = COV_ONE;
                started = 1'b1;
                series++;
            end
            // Add process noise, clamp at the top of the range
            p_sum = {1'b0, cov} + {1'b0, q_noise};
            p1    = p_sum[COV_W] ? COV_MAX : p_sum[COV_W-1:0];
            if (p_sum[COV_W]) begin
                saturations++;
            end
            // Gain P / (P + R), taken as one when the denominator vanishes
            den = {1'b0, p1} + {1'b0, r_noise};
            if (den == '0) begin
                k = GAIN_ONE;
                zero_dens++;
            end else begin
                wide = {1'b0, p1, {GF{1'b0}}} / {{GF{1'b0}}, den};
                k    = wide[GF:0];
            end
            if (k == GAIN_ONE) begin
                unity_gains++;
            end
            if (k == '0) begin
                zero_gains++;
            end
            // Move toward the sample, rounding the step half away from zero
            diff  = $signed({z[SW-1], z}) - $signed({est[SW-1], est});
            mag   = diff[SW] ? -diff : diff;
            adj   = (64'(mag) * 64'(k) + (64'd1 << (GF - 1))) >> GF;
            x_new = diff[SW] ? {est[SW-1], est} - adj[SW:0] : {est[SW-1], est} + adj[SW:0];
            est   = x_new[SW-1:0];
            // Shrink the covariance by (1 - k), truncating
            wide = WIDE_W'(p1) * WIDE_W'(GAIN_ONE - k);
            cov  = wide[COV_W+GF-1:GF];

            want.estimate = est;
            want.gain     = k;
            due_outputs.push_back(want);
        endfunction

        // Compare a delivered output with the oldest one owed
        function void check_output(logic [SW-1:0] estimate, logic [GF:0] gain);
            filter_out_t want;
            if (due_outputs.size() == 0) begin
                report($sformatf("output with no sample outstanding: estimate %0d gain %0d",
                                 $signed(estimate), gain));
                return;
            end
            want = due_outputs.pop_front();
            checked++;
            if (estimate !== want.estimate) begin
                report($sformatf("output %0d estimate: expected %0d, got %0d", checked,
                                 $signed(want.estimate), $signed(estimate)));
            end
            if (gain !== want.gain) begin
                report($sformatf("output %0d gain: expected %0d, got %0d", checked,
                                 want.gain, gain));
            end
        endfunction
    endclass

    kalman_scoreboard board;

    scalar_kalman_smoother DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_measurement     (i_measurement),
        .i_start_of_series (i_start_of_series),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_estimate        (o_estimate),
        .o_gain            (o_gain),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(30, 160);
    endfunction

    // Noise value from the corners or the body of the range, junk in the unused top bits
    function automatic logic [CFG_DATA_W-1:0] pick_noise();
        logic [COV_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = COV_MAX;
            2: v = COV_W'($urandom_range(1, 1 << 20));
            3: v = COV_ONE + COV_W'($urandom_range(0, 4096)) - COV_W'(2048);
            4: v = COV_W'({$urandom(), $urandom()});
            default: v = COV_W'($urandom()) << $urandom_range(0, 16);
        endcase
        return {16'($urandom()), v};
    endfunction

    // Write one noise register: setup cycle, then access cycle
    task automatic write_noise(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_noise(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one sample and hold it until the block takes the transaction
    task automatic send_sample(input logic [SW-1:0] z, input logic start);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            repeat (idle_length()) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_measurement     <= z;
        i_start_of_series <= start;
        do @(posedge i_clk); while (!o_ready);
        board.take_sample(z, start);
    endtask

    // Drop valid and wait for every owed output
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.due_outputs.size() != 0) @(negedge i_clk);
    endtask

    // Result side: random back-pressure, plus one long hold on request
    initial begin : result_sink
        int stall;
        stall   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall         = HOLD_CYCLES;
            end else if (stall == 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                stall = idle_length();
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_output(o_estimate, o_gain);
        end
    end

    initial begin : stimulus
        logic [SW-1:0] z;
        logic [SW-1:0] level;
        logic          start;
        int            settings;
        board             = new();
        settings          = 1;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_measurement     = '0;
        i_start_of_series = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset noise values; first sample without a start flag opens the series
        send_sample(SW'(1234), 1'b0);
        send_sample(Z_MAX, 1'b0);
        send_sample(Z_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(Z_MIN, 1'b1);
        send_sample(Z_MAX, 1'b0);
        send_sample(SW'(-1), 1'b0);
        send_sample(SW'(1), 1'b1);
        drain();

        // No noise at all: covariance collapses, then the denominator is zero
        write_noise(REG_PROCESS_NOISE, '0);
        write_noise(REG_MEASUREMENT_NOISE, '0);
        settings++;
        send_sample(SW'(100), 1'b1);
        send_sample(Z_MAX, 1'b0);
        send_sample(Z_MIN, 1'b0);
        send_sample(SW'(5), 1'b0);
        drain();

        // Both at full scale: covariance saturates
        write_noise(REG_PROCESS_NOISE, ALL_ONES);
        write_noise(REG_MEASUREMENT_NOISE, ALL_ONES);
        settings++;
        send_sample(Z_MIN, 1'b1);
        send_sample(Z_MAX, 1'b0);
        send_sample('0, 1'b0);
        drain();

        // Huge measurement noise: gain falls to zero
        write_noise(REG_PROCESS_NOISE, '0);
        write_noise(REG_MEASUREMENT_NOISE, {16'h0, COV_MAX});
        settings++;
        send_sample(Z_MAX, 1'b1);
        send_sample(Z_MIN, 1'b0);
        send_sample(SW'(7), 1'b0);
        drain();

        // Huge process noise, no measurement noise: gain is one
        write_noise(REG_PROCESS_NOISE, {16'h0, COV_MAX});
        write_noise(REG_MEASUREMENT_NOISE, '0);
        settings++;
        send_sample(SW'(-5), 1'b1);
        send_sample(Z_MAX, 1'b0);
        send_sample(Z_MIN, 1'b0);
        drain();

        // Random series around a level, with outliers and the odd restart
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_noise(REG_PROCESS_NOISE, pick_noise());
            write_noise(REG_MEASUREMENT_NOISE, pick_noise());
            settings++;
            src_idle_pct  = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 50);
            sink_idle_pct = (ph % 4 == 0) ? 0 : ((ph % 4 == 1) ? 40 : 15);
            if (ph == 3) begin
                sink_hold_req = 1'b1;
            end
            level = $urandom();
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                start = (n == 0 && ph % 2 == 0) || ($urandom_range(0, 99) < 6);
                if (start) begin
                    level = ($urandom_range(0, 1) == 1) ? $urandom()
                                                        : SW'($urandom_range(0, 1 << 16));
                end
                case ($urandom_range(0, 9))
                    0: z = Z_MAX;
                    1: z = Z_MIN;
                    2, 3: z = $urandom();
                    default: z = level + SW'($urandom_range(0, 1 << 12)) - SW'(1 << 11);
                endcase
                send_sample(z, start);
            end
            drain();
        end

        // Let the block settle, then close out
        repeat (LATENCY) @(negedge i_clk);
        if (board.due_outputs.size() != 0) begin
            board.report($sformatf("%0d outputs never arrived", board.due_outputs.size()));
        end
        $display("Ran %0d samples in %0d series under %0d noise settings; %0d outputs checked.",
                 board.samples, board.series, settings, board.checked);
        $display("Saturated covariance %0d, zero denominator %0d, unity gain %0d, zero gain %0d.",
                 board.saturations, board.zero_dens, board.unity_gains, board.zero_gains);
        if (board.errors == 0) begin
            $display("scalar_kalman_smoother: match");
        end else begin
            $display("%0d errors in total", board.errors);
            $display("scalar_kalman_smoother: mismatch");
        end
        $finish;
    end

    // End the run if a handshake never completes
    initial begin : watchdog
        #10_000_000;
        $display("timed out waiting for a transaction");
        $display("scalar_kalman_smoother: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sks_pkg.sv
rtl/sks_ctrl.sv
rtl/sks_datapath.sv
rtl/scalar_kalman_smoother.sv
tb/sv/testbench.sv
